### src/wes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wes_pkg
// Widths, register indexes and arithmetic constants of the wave stencil core.
// ----------------------------------------------------------------------------
package wes_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int COURANT_W  = 16;
	localparam int GRID_W     = 11;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_COURANT_SQ = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE  = 1'd1;

	localparam logic [COURANT_W-1:0] COURANT_RESET = 16'd16384;
	localparam logic [GRID_W-1:0]    GRID_RESET    = 11'd1024;
	localparam int                   MIN_GRID      = 3;

	// stencil sum, 2*centre - older, and the scaled product
	localparam int LAP_W   = 20;
	localparam int BASE_W  = 18;
	localparam int PROD_W  = LAP_W + COURANT_W + 1;
	localparam int FRAC_SH = 16;

	localparam int ROUND_BIAS = 32768;
	localparam int SAT_MAX    = 32767;
	localparam int SAT_MIN    = -32768;

endpackage

### src/wave_equation_stencil_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wave_equation_stencil_step_core
// Five-point finite-difference update of the 2-D wave equation on a raster
// stream, with line memories for the two rows above and the older samples.
// ----------------------------------------------------------------------------
// One word is accepted per clock unless stalled, a rate set by the single
// read and single write port of each line memory. One result per interior
// point passes stage 1, the sum and multiply stages and the output register
// after the word that completes its neighborhood (one row down, one column
// right); boundary points produce none. Line memories are not cleared:
// interior points of a normally started frame read only entries written
// earlier in that frame. Write courant_sq and grid_size only while the core
// is idle, which it does not enforce; grid_size is clamped to 3..MAX_GRID.
module wave_equation_stencil_step_core #(
	parameter int MAX_GRID = 1024,
	localparam int CW = $clog2(MAX_GRID)
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_we,
	input  logic [wes_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wes_pkg::CFG_DATA_W-1:0]      cfg_data,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [wes_pkg::SAMPLE_W-1:0] cur_value,
	input  logic signed [wes_pkg::SAMPLE_W-1:0] older_value,
	input  logic                                frame_start,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [CW-1:0]                       out_row,
	output logic [CW-1:0]                       out_col,
	output logic signed [wes_pkg::SAMPLE_W-1:0] new_value,
	output logic                                frame_last
);

	localparam int NW = $clog2(MAX_GRID + 1);
	localparam int EW = (NW > wes_pkg::GRID_W) ? NW : wes_pkg::GRID_W;
	localparam int SW = wes_pkg::SAMPLE_W;
	localparam int PW = wes_pkg::PROD_W;

	// configuration
	logic [wes_pkg::COURANT_W-1:0] courant_q;
	logic [wes_pkg::GRID_W-1:0]    grid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			courant_q <= wes_pkg::COURANT_RESET;
			grid_q    <= wes_pkg::GRID_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				wes_pkg::REG_COURANT_SQ: courant_q <= cfg_data[wes_pkg::COURANT_W-1:0];
				wes_pkg::REG_GRID_SIZE:  grid_q    <= cfg_data[wes_pkg::GRID_W-1:0];
				default: ;
			endcase
		end
	end

	logic [EW-1:0] grid_ext, n_ext;
	logic [NW-1:0] n;

	always_comb begin
		grid_ext = EW'(grid_q);
		if (grid_ext < EW'(wes_pkg::MIN_GRID))
			n_ext = EW'(wes_pkg::MIN_GRID);
		else if (grid_ext > EW'(MAX_GRID))
			n_ext = EW'(MAX_GRID);
		else
			n_ext = grid_ext;
		n = n_ext[NW-1:0];
	end

	// handshake
	logic v1, v2, v3;
	logic out_ready, rdy3, rdy2, rdy1, in_accept, adv1;

	assign out_ready = !out_valid || !out_stall;
	assign rdy3      = !v3 || out_ready;
	assign rdy2      = !v2 || rdy3;
	assign rdy1      = !v1 || rdy2;
	assign in_stall  = !rdy1;
	assign in_accept = in_valid && rdy1;
	assign adv1      = v1 && rdy2;

	// position
	logic [CW-1:0] col_q, row_q;
	logic [NW-1:0] c_pre, r_pre, r_mid, c0, r0, c_nxt, r_nxt;
	logic [CW-1:0] addr;
	logic          int0, last0;

	always_comb begin
		c_pre = frame_start ? '0 : NW'(col_q);
		r_pre = frame_start ? '0 : NW'(row_q);
		if (c_pre >= n) begin
			c0    = '0;
			r_mid = r_pre + NW'(1);
		end else begin
			c0    = c_pre;
			r_mid = r_pre;
		end
		r0 = (r_mid >= n) ? '0 : r_mid;
		c_nxt = c0 + NW'(1);
		r_nxt = r0;
		if (c_nxt >= n) begin
			c_nxt = '0;
			r_nxt = r0 + NW'(1);
			if (r_nxt >= n)
				r_nxt = '0;
		end
		addr  = c0[CW-1:0];
		int0  = (r0 >= NW'(2)) && (c0 >= NW'(2));
		last0 = (r0 == n - NW'(1)) && (c0 == n - NW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_accept) begin
			col_q <= c_nxt[CW-1:0];
			row_q <= r_nxt[CW-1:0];
		end
	end

	// line memories
	logic signed [SW-1:0] above_mem [MAX_GRID];
	logic signed [SW-1:0] two_mem   [MAX_GRID];
	logic signed [SW-1:0] older_mem [MAX_GRID];

	logic signed [SW-1:0] a1_s1, a2_rd_s1, o1_s1, cur_s1, fwd_data_s1;
	logic [CW-1:0]        c_s1, orow_s1, ocol_s1;
	logic                 int_s1, last_s1, fwd_s1;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			a1_s1           <= above_mem[addr];
			above_mem[addr] <= cur_value;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			o1_s1           <= older_mem[addr];
			older_mem[addr] <= older_value;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept)
			a2_rd_s1 <= two_mem[addr];
		if (adv1)
			two_mem[c_s1] <= a1_s1;
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cur_s1      <= cur_value;
			c_s1        <= addr;
			orow_s1     <= CW'(r0 - NW'(1));
			ocol_s1     <= CW'(c0 - NW'(1));
			last_s1     <= last0;
			fwd_data_s1 <= a1_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1     <= 1'b0;
			int_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (rdy1) begin
			v1 <= in_valid;
			// two-row write of the word leaving stage 1 lands at the address read now
			fwd_s1 <= in_valid && adv1 && (c_s1 == addr);
			if (in_valid)
				int_s1 <= int0;
		end
	end

	// window
	logic signed [SW-1:0] a2_s1;
	logic signed [SW-1:0] w_up, w_centre, w_left, w_down, older_hold_q;

	assign a2_s1 = fwd_s1 ? fwd_data_s1 : a2_rd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_up         <= '0;
			w_centre     <= '0;
			w_left       <= '0;
			w_down       <= '0;
			older_hold_q <= '0;
		end else if (adv1) begin
			w_up         <= a2_s1;
			w_left       <= w_centre;
			w_centre     <= a1_s1;
			w_down       <= cur_s1;
			older_hold_q <= o1_s1;
		end
	end

	logic signed [wes_pkg::LAP_W-1:0]  lap1;
	logic signed [wes_pkg::BASE_W-1:0] base1;

	always_comb begin
		lap1  = wes_pkg::LAP_W'(w_up) + wes_pkg::LAP_W'(w_down)
		      + wes_pkg::LAP_W'(w_left) + wes_pkg::LAP_W'(a1_s1)
		      - (wes_pkg::LAP_W'(w_centre) <<< 2);
		base1 = (wes_pkg::BASE_W'(w_centre) <<< 1) - wes_pkg::BASE_W'(older_hold_q);
	end

	// stages 2 and 3: stencil sum and scaled product
	logic signed [wes_pkg::LAP_W-1:0]  lap_s2;
	logic signed [wes_pkg::BASE_W-1:0] base_s2, base_s3;
	logic [CW-1:0]                     row_s2, col_s2, row_s3, col_s3;
	logic                              last_s2, last_s3;
	logic signed [PW-1:0]              prod_s3;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			lap_s2  <= lap1;
			base_s2 <= base1;
			row_s2  <= orow_s1;
			col_s2  <= ocol_s1;
			last_s2 <= last_s1;
		end
		if (rdy3) begin
			prod_s3 <= lap_s2 * $signed({1'b0, courant_q});
			base_s3 <= base_s2;
			row_s3  <= row_s2;
			col_s3  <= col_s2;
			last_s3 <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2 <= 1'b0;
			v3 <= 1'b0;
		end else begin
			if (rdy2)
				v2 <= adv1 && int_s1;
			if (rdy3)
				v3 <= v2;
		end
	end

	// round, add, saturate
	logic signed [PW-1:0] total;
	logic signed [SW-1:0] sat;

	always_comb begin
		total = ((prod_s3 + PW'(wes_pkg::ROUND_BIAS)) >>> wes_pkg::FRAC_SH) + PW'(base_s3);
		if (total > PW'(wes_pkg::SAT_MAX))
			sat = SW'(wes_pkg::SAT_MAX);
		else if (total < PW'(wes_pkg::SAT_MIN))
			sat = SW'(wes_pkg::SAT_MIN);
		else
			sat = total[SW-1:0];
	end

	always_ff @(posedge clk) begin
		if (out_ready) begin
			new_value  <= sat;
			out_row    <= row_s3;
			out_col    <= col_s3;
			frame_last <= last_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (out_ready)
			out_valid <= v3;
	end

	// checks
	a_empty_not_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!v1 |-> !in_stall)
		else $error("input stalled with stage 1 empty");

	a_fwd_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> v1)
		else $error("forward flag set with stage 1 empty");

	a_interior_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_row != '0) && (out_col != '0))
		else $error("boundary point emitted");

	a_last_diag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |-> out_row == out_col)
		else $error("last point off the diagonal");

endmodule
